[design/upd_pkg.sv]
package upd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CAP_W       = 16;
  localparam int LEN_W       = 16;
  localparam int CHAR_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CMP_W       = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 1;

  localparam logic [CAP_W-1:0]       CAPACITY_RESET = CAP_W'(256);
  localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT    = {COUNT_WIDTH{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLUS_MEANS_SPACE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY         = 1'd1;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL     = 8'h7f;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [3:0]             high_nibble;
    logic [COUNT_WIDTH-1:0] count;
    logic                   err;
  } dec_state_t;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0]  out_length;
    logic              failed;
    logic              run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } step_out_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [CHAR_W-1:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_control(input logic [CHAR_W-1:0] b);
    return (b < CH_SPACE) || (b == CH_DEL);
  endfunction

endpackage

[design/upd_in_if.sv]
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] char_in;
  logic       end_of_string;

  modport source (output valid, has_byte, char_in, end_of_string, input ready);
  modport sink   (input valid, has_byte, char_in, end_of_string, output ready);
endinterface

[design/upd_out_if.sv]
interface upd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  char_out;
  logic [15:0] out_length;
  logic        failed;
  logic        run_last;

  modport source (output valid, kind, char_out, out_length, failed, run_last,
                  input ready);
  modport sink   (input valid, kind, char_out, out_length, failed, run_last,
                  output ready);
endinterface

[design/upd_step.sv]
module upd_step (
  input  upd_pkg::dec_state_t              st,
  input  logic                             plus_means_space,
  input  logic [upd_pkg::CAP_W-1:0]        capacity,
  input  logic                             has_byte,
  input  logic [upd_pkg::CHAR_W-1:0]       char_in,
  input  logic                             end_of_string,
  output upd_pkg::dec_state_t              st_next,
  output upd_pkg::step_out_t               res
);
  import upd_pkg::*;

  dec_state_t        nx;
  hex_t              hd;
  logic              emit_req;
  logic [CHAR_W-1:0] emit_b;
  logic [CHAR_W-1:0] esc_b;
  logic [CMP_W-1:0]  cap_wide;
  logic [CMP_W-1:0]  cnt_plus;
  logic              full;
  logic              data_ok;
  result_t           data_r;
  result_t           end_r;

  always_comb begin
    nx       = st;
    emit_req = 1'b0;
    emit_b   = '0;
    hd       = hex_digit(char_in);
    esc_b    = {st.high_nibble, hd.value};
    cap_wide = CMP_W'(capacity);
    cnt_plus = CMP_W'(st.count) + CMP_W'(1);
    data_ok  = 1'b0;

    if (has_byte && !st.err) begin
      unique case (st.phase)
        PH_HIGH: begin
          if (!hd.ok) begin
            nx.err   = 1'b1;
            nx.phase = PH_NONE;
          end else begin
            nx.high_nibble = hd.value;
            nx.phase       = PH_LOW;
          end
        end
        PH_LOW: begin
          nx.phase = PH_NONE;
          if (!hd.ok || is_control(esc_b)) begin
            nx.err = 1'b1;
          end else begin
            emit_req = 1'b1;
            emit_b   = esc_b;
          end
        end
        default: begin
          nx.phase = PH_NONE;
          if (char_in == CH_PERCENT) begin
            nx.phase = PH_HIGH;
          end else if (plus_means_space && char_in == CH_PLUS) begin
            emit_req = 1'b1;
            emit_b   = CH_SPACE;
          end else if (is_control(char_in)) begin
            nx.err = 1'b1;
          end else begin
            emit_req = 1'b1;
            emit_b   = char_in;
          end
        end
      endcase
    end

    // keep one place for the terminator; saturating counter counts as full
    full = (cnt_plus >= cap_wide) || (st.count == COUNT_LIMIT);
    if (emit_req) begin
      if (full) begin
        nx.err = 1'b1;
      end else begin
        nx.count = st.count + COUNT_WIDTH'(1);
        data_ok  = 1'b1;
      end
    end

    data_r.kind       = KIND_DATA;
    data_r.char_out   = emit_b;
    data_r.out_length = LEN_W'(nx.count);
    data_r.failed     = 1'b0;
    data_r.run_last   = !end_of_string;

    end_r.kind       = KIND_END;
    end_r.char_out   = '0;
    end_r.out_length = LEN_W'(nx.count);
    end_r.failed     = nx.err || (nx.phase != PH_NONE) ||
                       (CMP_W'(nx.count) >= cap_wide);
    end_r.run_last   = 1'b1;

    if (end_of_string) begin
      nx.phase       = PH_NONE;
      nx.high_nibble = 4'd0;
      nx.count       = '0;
      nx.err         = 1'b0;
    end

    res.num    = 2'(data_ok) + 2'(end_of_string);
    res.first  = data_ok ? data_r : end_r;
    res.second = end_r;
    st_next    = nx;
  end

endmodule

[design/url_percent_decoder.sv]
// Channel  | Dir | Carries
// ---------+-----+--------------------------------------------------------
// enc      | in  | has_byte, char_in, end_of_string (one encoded request)
// dec      | out | kind, char_out, out_length, failed, run_last
// cfg      | in  | cfg_we, cfg_index, cfg_data (plus_means_space, capacity)
//
// One request is taken per cycle while enc.ready is high. Each request is
// decoded in the cycle it is accepted and yields zero, one or two results,
// which go into a four-entry result queue; the queue head drives dec. A
// request that makes both a data byte and the end summary puts two entries
// into the queue. enc.ready drops while fewer than two queue places are free.
// Synchronous reset clears the decoder state, the queue and the registers
// (plus_means_space = 0, capacity = 256).
module url_percent_decoder (
  input  logic                          clk,
  input  logic                          rst,
  upd_in_if.sink                        enc,
  upd_out_if.source                     dec,
  input  logic                          cfg_we,
  input  logic [upd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [upd_pkg::CAP_W-1:0]     cfg_data
);
  import upd_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  logic              plus_means_space;
  logic [CAP_W-1:0]  capacity;
  dec_state_t        st;
  dec_state_t        st_next;
  step_out_t         res;

  result_t           queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic [QPTR_W:0]   fill_next;
  logic              take;
  logic              give;

  // Decode one request against the current string state.
  upd_step u_step (
    .st               (st),
    .plus_means_space (plus_means_space),
    .capacity         (capacity),
    .has_byte         (enc.has_byte),
    .char_in          (enc.char_in),
    .end_of_string    (enc.end_of_string),
    .st_next          (st_next),
    .res              (res)
  );

  // Accept only while two result places are free.
  assign enc.ready = (fill <= (QPTR_W+1)'(QDEPTH - 2));
  assign take      = enc.valid && enc.ready;
  assign give      = dec.valid && dec.ready;

  assign dec.valid      = (fill != '0);
  assign dec.kind       = queue[rd_ptr].kind;
  assign dec.char_out   = queue[rd_ptr].char_out;
  assign dec.out_length = queue[rd_ptr].out_length;
  assign dec.failed     = queue[rd_ptr].failed;
  assign dec.run_last   = queue[rd_ptr].run_last;

  always_comb begin
    fill_next = fill;
    if (take) begin
      fill_next = fill_next + (QPTR_W+1)'(res.num);
    end
    if (give) begin
      fill_next = fill_next - (QPTR_W+1)'(1);
    end
  end

  // Configuration registers: the user must write them only while idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      plus_means_space <= 1'b0;
      capacity         <= CAPACITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLUS_MEANS_SPACE: plus_means_space <= cfg_data[0];
        REG_CAPACITY:         capacity         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance string state on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= PH_NONE;
      st.high_nibble <= 4'd0;
      st.count       <= '0;
      st.err         <= 1'b0;
    end else if (take) begin
      st <= st_next;
    end
  end

  // Result queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (take) begin
        wr_ptr <= wr_ptr + QPTR_W'(res.num);
      end
      if (give) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
  end

  // Result payload: push up to two entries, no reset needed.
  always_ff @(posedge clk) begin
    if (take && res.num != 2'd0) begin
      queue[wr_ptr] <= res.first;
    end
    if (take && res.num == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= res.second;
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import upd_pkg::*;

  // Run ceiling in clock cycles, far above the slowest correct run.
  localparam int unsigned RUN_LIMIT   = 400000;
  // Cycles to let pass after the last expected result before a register write,
  // so that requests that make no result have cleared the pipeline.
  localparam int unsigned QUIET_WAIT  = 8;
  // Tail after the final result, long enough for any stray result to show.
  localparam int unsigned TAIL_CYCLES = 20;
  // Length of the long receiver hold-off used to fill the block.
  localparam int unsigned LONG_HOLD   = 300;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CAP_W-1:0]     cfg_data;

  upd_in_if  enc_if ();
  upd_out_if dec_if ();

  url_percent_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .enc       (enc_if),
    .dec       (dec_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Decoder shadow: its own copy of the registers and of the per-string state.
  bit          plus_mode  = 1'b0;
  int unsigned cap_limit  = 256;
  phase_t      esc_phase  = PH_NONE;
  logic [3:0]  esc_nibble = '0;
  int unsigned emitted    = 0;
  bit          err_seen   = 1'b0;

  result_t     step_results[$];
  result_t     expected_results[$];

  // Run bookkeeping.
  int unsigned error_count     = 0;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned strings_sent    = 0;
  int unsigned settings_used   = 0;
  int unsigned long_holds      = 0;
  int unsigned cycle_count     = 0;

  // Idle control for both sides.
  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned src_calm     = 0;
  int unsigned sink_calm    = 0;
  int unsigned sink_stall   = 0;
  int unsigned hold_request = 0;

  // ---------------------------------------------------------------------------
  // Decoder shadow
  // ---------------------------------------------------------------------------

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic bit is_ctrl_byte(logic [7:0] b);
    return (b < 8'h20) || (b == 8'h7f);
  endfunction

  function automatic void push_result(logic kind, logic [7:0] ch, bit fail);
    result_t r;
    r.kind       = kind;
    r.char_out   = ch;
    r.out_length = LEN_W'(emitted);
    r.failed     = fail;
    r.run_last   = 1'b0;
    step_results.push_back(r);
  endfunction

  // Emit one decoded byte unless it would fill the buffer or wrap the counter.
  function automatic void emit_decoded(logic [7:0] b);
    if (emitted + 1 >= cap_limit || emitted >= COUNT_LIMIT) begin
      err_seen = 1'b1;
      return;
    end
    emitted++;
    push_result(KIND_DATA, b, 1'b0);
  endfunction

  function automatic void decode_byte(logic [7:0] c);
    int         v;
    logic [7:0] b;
    if (err_seen) return;
    if (esc_phase == PH_HIGH) begin
      v = hex_value(c);
      if (v < 0) begin
        err_seen  = 1'b1;
        esc_phase = PH_NONE;
        return;
      end
      esc_nibble = v[3:0];
      esc_phase  = PH_LOW;
      return;
    end
    if (esc_phase == PH_LOW) begin
      esc_phase = PH_NONE;
      v = hex_value(c);
      if (v < 0) begin
        err_seen = 1'b1;
        return;
      end
      b = {esc_nibble, v[3:0]};
      if (is_ctrl_byte(b)) begin
        err_seen = 1'b1;
        return;
      end
      emit_decoded(b);
      return;
    end
    if (c == CH_PERCENT) begin
      esc_phase = PH_HIGH;
      return;
    end
    if (plus_mode && c == CH_PLUS) begin
      emit_decoded(CH_SPACE);
      return;
    end
    if (is_ctrl_byte(c)) begin
      err_seen = 1'b1;
      return;
    end
    emit_decoded(c);
  endfunction

  // Work out every result one accepted request causes and queue them.
  function automatic void predict_request(logic hb, logic [7:0] c, logic eos);
    result_t r;
    step_results.delete();
    if (hb) decode_byte(c);
    if (eos) begin
      if (esc_phase != PH_NONE) err_seen = 1'b1;
      if (emitted >= cap_limit) err_seen = 1'b1;
      push_result(KIND_END, 8'h00, err_seen);
      esc_phase  = PH_NONE;
      esc_nibble = '0;
      emitted    = 0;
      err_seen   = 1'b0;
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.run_last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted request, then check each accepted result.
  // A result can never stem from a request taken at the same edge, so doing
  // both in one process keeps the expectation queue in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst) begin
      if (enc_if.valid && enc_if.ready)
        predict_request(enc_if.has_byte, enc_if.char_in, enc_if.end_of_string);
      if (dec_if.valid && dec_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0b char %0h len %0d",
                   $time, dec_if.kind, dec_if.char_out, dec_if.out_length);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("kind",       exp_r.kind,       dec_if.kind);
          check_field("char_out",   exp_r.char_out,   dec_if.char_out);
          check_field("out_length", exp_r.out_length, dec_if.out_length);
          check_field("failed",     exp_r.failed,     dec_if.failed);
          check_field("run_last",   exp_r.run_last,   dec_if.run_last);
          results_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, calm stretches, and a long hold-off on
  // request from a test, all counted here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request != 0) begin
      sink_stall   = hold_request;
      hold_request = 0;
    end else if (sink_stall == 0) begin
      if (sink_calm > 0)
        sink_calm--;
      else if (sink_idle_on && $urandom_range(0, 59) == 0)
        sink_calm = $urandom_range(20, 60);
      else if (sink_idle_on && $urandom_range(0, 3) == 0)
        sink_stall = $urandom_range(1, 4);
    end
    if (sink_stall > 0) begin
      dec_if.ready <= 1'b0;
      sink_stall--;
    end else begin
      dec_if.ready <= 1'b1;
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("%0t: timeout with %0d results still expected", $time,
               expected_results.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until the block takes it.
  task automatic send_request(logic hb, logic [7:0] c, logic eos);
    int unsigned gap;
    if (src_calm > 0) begin
      src_calm--;
    end else if (src_idle_on && $urandom_range(0, 59) == 0) begin
      src_calm = $urandom_range(20, 60);
    end else if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      enc_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    enc_if.valid         <= 1'b1;
    enc_if.has_byte      <= hb;
    enc_if.char_in       <= c;
    enc_if.end_of_string <= eos;
    @(posedge clk);
    while (!enc_if.ready) @(posedge clk);
    requests_sent++;
    if (eos) strings_sent++;
  endtask

  // Send a printable string, ending it on its last byte.
  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(1'b1, s[i], i == s.len() - 1);
  endtask

  // Drop valid, drain every expected result, then let the pipeline settle.
  task automatic wait_quiet();
    enc_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (QUIET_WAIT) @(posedge clk);
  endtask

  // Write one register while the block is idle and mirror it in the shadow.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] value);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PLUS_MEANS_SPACE: plus_mode = value[0];
      REG_CAPACITY:         cap_limit = value;
      default: ;
    endcase
    settings_used++;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 10) return 8'("0") + 8'(v);
    return (upper ? 8'("A") : 8'("a")) + 8'(v - 10);
  endfunction

  // Build one string and send it. Mostly well-formed content; noisy strings
  // mix in raw bytes, broken escapes, cut-off escapes and ignored requests.
  // A negative entry stands for an ignored request (no byte, no end).
  task automatic send_random_string(bit noisy);
    int         items[$];
    int         parts;
    int         sel;
    bit         end_inline;
    logic [7:0] b;
    parts = $urandom_range(0, 12);
    repeat (parts) begin
      sel = $urandom_range(0, noisy ? 9 : 5);
      case (sel)
        0, 1: begin
          b = 8'($urandom_range(8'h20, 8'h7e));
          if (b == CH_PERCENT) b = "x";
          items.push_back(b);
        end
        2: items.push_back(int'($urandom_range(8'h80, 8'hff)));
        3: items.push_back(CH_PLUS);
        4, 5: begin
          if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
          else b = 8'($urandom_range(8'h20, 8'h7e));
          items.push_back(CH_PERCENT);
          items.push_back(hex_char(b[7:4], 1'($urandom_range(0, 1))));
          items.push_back(hex_char(b[3:0], 1'($urandom_range(0, 1))));
        end
        6: items.push_back(int'($urandom_range(0, 255)));
        7: begin
          items.push_back(CH_PERCENT);
          items.push_back(int'($urandom_range(0, 255)));
        end
        8: items.push_back(-1);
        default: begin
          items.push_back(CH_PERCENT);
          if ($urandom_range(0, 1)) items.push_back(hex_char(4'($urandom_range(0, 15)), 1'b1));
        end
      endcase
    end
    end_inline = $urandom_range(0, 1) && items.size() > 0 && items[$] >= 0;
    foreach (items[i]) begin
      if (items[i] < 0) send_request(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      else send_request(1'b1, 8'(items[i]), end_inline && i == items.size() - 1);
    end
    if (!end_inline) send_request(1'b0, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: escapes in both cases, plus passes through, high bytes.
  task automatic test_plain_decoding();
    send_text("%41%6a+~");
    send_request(1'b1, 8'hff, 1'b0);
    send_request(1'b0, 8'h00, 1'b1);
    send_text("%Fe%b0");
  endtask

  task automatic test_error_cases();
    send_text("%7Fz");                  // decoded DEL, then a byte after error
    send_text("%g1");                   // non-hex escape digit
    send_request(1'b1, 8'h00, 1'b0);    // literal control byte
    send_request(1'b1, "a", 1'b1);
    send_request(1'b0, 8'hff, 1'b0);    // no byte, no end: ignored
    send_text("b%A");                   // escape cut off by the end
    send_request(1'b0, 8'h00, 1'b1);    // empty string
  endtask

  task automatic test_query_mode();
    write_register(REG_PLUS_MEANS_SPACE, CAP_W'(1));
    send_text("a+b%2B");                // decoded plus stays a plus
    send_text("%41");                   // data and end from one request
  endtask

  task automatic test_capacity_limits();
    write_register(REG_CAPACITY, CAP_W'(0));
    send_request(1'b0, 8'h00, 1'b1);    // empty string still fails
    write_register(REG_CAPACITY, CAP_W'(1));
    send_request(1'b0, 8'h00, 1'b1);
    send_text("a");
    write_register(REG_CAPACITY, CAP_W'(3));
    send_text("abcd");                  // third byte would fill the buffer
    write_register(REG_CAPACITY, 16'hffff);
    send_text("xy%7e");
  endtask

  // Hold the receiver off while the sender keeps offering, so the result
  // queue fills and enc.ready drops.
  task automatic test_output_backpressure();
    write_register(REG_CAPACITY, CAP_W'(256));
    src_idle_on  = 1'b0;
    hold_request = LONG_HOLD;
    long_holds++;
    repeat (5) send_text("abcdefgh");
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_strings(bit plus, int unsigned cap, int unsigned count);
    int unsigned target;
    write_register(REG_PLUS_MEANS_SPACE, CAP_W'(plus));
    write_register(REG_CAPACITY, CAP_W'(cap));
    target = requests_sent + count;
    while (requests_sent < target) send_random_string($urandom_range(0, 3) == 0);
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    enc_if.valid         = 1'b0;
    enc_if.has_byte      = 1'b0;
    enc_if.char_in       = '0;
    enc_if.end_of_string = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_plain_decoding();
    test_error_cases();
    test_query_mode();
    test_capacity_limits();
    test_output_backpressure();

    test_random_strings(1'b0, 256,    300);
    test_random_strings(1'b1, 256,    300);
    test_random_strings(1'b1, 6,      200);
    test_random_strings(1'b0, 16'hffff, 200);
    test_random_strings(1'($urandom_range(0, 1)), $urandom_range(0, 20), 200);
    test_random_strings(1'b0, 1,      100);
    test_random_strings(1'b1, 0,      50);

    // Close at full rate on both sides.
    wait_quiet();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random_strings(1'b1, 256, 300);

    // Drain, then watch a short tail for stray results.
    enc_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d requests in %0d strings, %0d results checked", requests_sent,
             strings_sent, results_checked);
    $display("tb: %0d register writes, %0d long receiver hold-offs", settings_used,
             long_holds);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
